// ===== design/tsf_pkg.sv =====
// tsf_pkg: shared types and constants for the triangle span filler.
// Used by triangle_scanline_span_filler; depends on nothing else.
`default_nettype none

package tsf_pkg;

	// op field codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// colour table has entries 0..COLOUR_LAST
	localparam logic [2:0] COLOUR_LAST = 3'd4;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MUL,
		SEQ_DIV_START,
		SEQ_DIV_WAIT
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_BOTTOM,
		PH_TOP
	} fill_phase_t;

	typedef enum logic [2:0] {
		JOB_SPLIT,
		JOB_SLOPE0,
		JOB_SLOPE1,
		JOB_SLOPE2,
		JOB_SLOPE3
	} div_job_t;

	typedef struct packed {
		logic red;
		logic green;
		logic blue;
	} colour_t;

	function automatic colour_t colour_of(input logic [2:0] slot);
		colour_t c;
		unique case (slot)
			3'd0: c = '{red: 1'b1, green: 1'b0, blue: 1'b0};
			3'd1: c = '{red: 1'b0, green: 1'b1, blue: 1'b0};
			3'd2: c = '{red: 1'b0, green: 1'b0, blue: 1'b1};
			3'd3: c = '{red: 1'b1, green: 1'b0, blue: 1'b1};
			3'd4: c = '{red: 1'b1, green: 1'b1, blue: 1'b0};
			default: c = '{red: 1'b1, green: 1'b0, blue: 1'b0};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/triangle_scanline_span_filler.sv =====
// triangle_scanline_span_filler: sorts a triangle, derives fixed-point edge slopes
// and emits one horizontal span per step word. Uses tsf_pkg and tsf_divider.
//
//   channel | signals                                  | role
//   --------+------------------------------------------+------------------------------
//   in      | in_valid, in_ready, op, vertex_*         | load triangle (op 0) or step
//   out     | out_valid, out_ready, span_*, rgb, last  | one span word per step
//
// A step word's span sits in an output register, so steps
// stream one per cycle while out_ready stays high.
// A load runs the split point and four slopes one after another through a single
// bit-serial divider, one quotient bit per cycle. in_ready is low meanwhile.
// Reset clears the sequencer, fill phase, colour slot and output valid.
// A stalled output holds in_ready low.
`default_nettype none

module triangle_scanline_span_filler #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  op,
	input  wire logic [COORD_BITS-1:0] vertex_a_x,
	input  wire logic [COORD_BITS-1:0] vertex_a_y,
	input  wire logic [COORD_BITS-1:0] vertex_b_x,
	input  wire logic [COORD_BITS-1:0] vertex_b_y,
	input  wire logic [COORD_BITS-1:0] vertex_c_x,
	input  wire logic [COORD_BITS-1:0] vertex_c_y,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [COORD_BITS-1:0] span_row,
	output logic      [COORD_BITS-1:0] span_left,
	output logic      [COORD_BITS-1:0] span_right,
	output logic                       red,
	output logic                       green,
	output logic                       blue,
	output logic                       last_span
);

	localparam int C  = COORD_BITS;
	localparam int XW = COORD_BITS + FRAC_BITS + 2;     // edge x and slope width
	localparam int PW = 2 * COORD_BITS;                 // dy * dx product
	localparam int NW = 2 * COORD_BITS + FRAC_BITS;     // divider numerator

	function automatic logic signed [XW-1:0] fix(input logic [C-1:0] v);
		return {2'b00, v, {FRAC_BITS{1'b0}}};
	endfunction

	// floor to pixel, clamp to screen
	function automatic logic [C-1:0] pix(input logic signed [XW-1:0] v);
		logic [C+1:0] p;
		p = v[XW-1:FRAC_BITS];
		if (v[XW-1])
			return '0;
		else if (p[C])
			return '1;
		else
			return p[C-1:0];
	endfunction

	tsf_pkg::seq_state_t  state_q, state_d;
	tsf_pkg::fill_phase_t phase_q, phase_nx;
	tsf_pkg::div_job_t    job_q;
	logic [2:0]           colour_q;

	logic in_acc, load_acc, step_acc, span_has;

	// sorted vertices
	logic [C-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
	logic [C-1:0] sx [3];
	logic [C-1:0] sy [3];

	logic [PW-1:0] prod_q;
	logic          prod_neg_q;

	logic signed [XW-1:0] split_q;
	logic signed [XW-1:0] s0_q, s1_q, s2_q, s3_q;
	logic signed [XW-1:0] ex0_q, ex1_q, ex0_nx, ex1_nx;
	logic [C-1:0]         row_q, row_nx;

	// divider hookup
	logic                 div_start, div_done;
	logic [NW-1:0]        div_num, div_quo;
	logic [C-1:0]         div_den;
	logic                 div_neg;
	logic                 neg_q, den_zero_q;
	logic signed [XW-1:0] num_s, num_abs, quo_s, div_res;

	// span datapath
	logic [C-1:0]         span_a, span_b;
	logic                 span_last;
	logic signed [XW-1:0] top_n0, top_n1;
	tsf_pkg::colour_t     colour;

	logic                 out_valid_q;
	logic [C-1:0]         row_s1, left_s1, right_s1;
	tsf_pkg::colour_t     colour_s1;
	logic                 last_s1;

	assign in_ready = (state_q == tsf_pkg::SEQ_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign load_acc = in_acc && (op == tsf_pkg::OP_LOAD);
	assign step_acc = in_acc && (op == tsf_pkg::OP_STEP);
	assign span_has = (phase_q == tsf_pkg::PH_BOTTOM) || (phase_q == tsf_pkg::PH_TOP);

	// sort by y: compare-and-swap (0,1), (0,2), (1,2)
	always_comb begin
		logic [C-1:0] tx, ty;
		tx = '0;
		ty = '0;
		sx[0] = vertex_a_x; sy[0] = vertex_a_y;
		sx[1] = vertex_b_x; sy[1] = vertex_b_y;
		sx[2] = vertex_c_x; sy[2] = vertex_c_y;
		if (sy[0] > sy[1]) begin
			tx = sx[0]; ty = sy[0];
			sx[0] = sx[1]; sy[0] = sy[1];
			sx[1] = tx; sy[1] = ty;
		end
		if (sy[0] > sy[2]) begin
			tx = sx[0]; ty = sy[0];
			sx[0] = sx[2]; sy[0] = sy[2];
			sx[2] = tx; sy[2] = ty;
		end
		if (sy[1] > sy[2]) begin
			tx = sx[1]; ty = sy[1];
			sx[1] = sx[2]; sy[1] = sy[2];
			sx[2] = tx; sy[2] = ty;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tsf_pkg::SEQ_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			tsf_pkg::SEQ_IDLE: begin
				if (load_acc)
					state_d = tsf_pkg::SEQ_MUL;
			end
			tsf_pkg::SEQ_MUL: begin
				state_d = tsf_pkg::SEQ_DIV_START;
			end
			tsf_pkg::SEQ_DIV_START: begin
				div_start = 1'b1;
				state_d   = tsf_pkg::SEQ_DIV_WAIT;
			end
			tsf_pkg::SEQ_DIV_WAIT: begin
				if (div_done)
					state_d = (job_q == tsf_pkg::JOB_SLOPE3) ? tsf_pkg::SEQ_IDLE
					                                         : tsf_pkg::SEQ_DIV_START;
			end
			default: state_d = tsf_pkg::SEQ_IDLE;
		endcase
	end

	// numerator and denominator of the current division
	always_comb begin
		num_s = '0;
		unique case (job_q)
			tsf_pkg::JOB_SLOPE0: num_s = fix(x1_q) - fix(x0_q);
			tsf_pkg::JOB_SLOPE1: num_s = split_q - fix(x0_q);
			tsf_pkg::JOB_SLOPE2: num_s = fix(x2_q) - fix(x1_q);
			tsf_pkg::JOB_SLOPE3: num_s = fix(x2_q) - split_q;
			default:             num_s = '0;
		endcase
		num_abs = num_s[XW-1] ? -num_s : num_s;
		if (job_q == tsf_pkg::JOB_SPLIT) begin
			div_num = {prod_q, {FRAC_BITS{1'b0}}};
			div_neg = prod_neg_q;
			div_den = y2_q - y0_q;
		end else begin
			div_num = {{(NW-XW){1'b0}}, num_abs};
			div_neg = num_s[XW-1];
			div_den = ((job_q == tsf_pkg::JOB_SLOPE0) || (job_q == tsf_pkg::JOB_SLOPE1))
			        ? (y1_q - y0_q) : (y2_q - y1_q);
		end
	end

	tsf_divider #(
		.NUM_BITS(NW),
		.DEN_BITS(C)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// truncating division: sign applied to magnitude, zero divisor gives zero
	assign quo_s   = div_quo[XW-1:0];
	assign div_res = den_zero_q ? '0 : (neg_q ? -quo_s : quo_s);

	// span of the current row
	assign top_n0 = ex0_q - s2_q;
	assign top_n1 = ex1_q - s3_q;

	always_comb begin
		span_a    = '0;
		span_b    = '0;
		span_last = 1'b0;
		ex0_nx    = ex0_q;
		ex1_nx    = ex1_q;
		row_nx    = row_q;
		phase_nx  = phase_q;
		unique case (phase_q)
			tsf_pkg::PH_BOTTOM: begin
				span_a = pix(ex0_q);
				span_b = pix(ex1_q);
				ex0_nx = ex0_q + s0_q;
				ex1_nx = ex1_q + s1_q;
				if (row_q >= y1_q) begin
					if (y2_q > y1_q) begin
						phase_nx = tsf_pkg::PH_TOP;
						row_nx   = y2_q;
						ex0_nx   = fix(x2_q);
						ex1_nx   = fix(x2_q);
					end else begin
						span_last = 1'b1;
					end
				end else begin
					row_nx = row_q + C'(1);
				end
			end
			tsf_pkg::PH_TOP: begin
				ex0_nx = top_n0;
				ex1_nx = top_n1;
				span_a = pix(top_n0);
				span_b = pix(top_n1);
				if ({1'b0, row_q} <= ({1'b0, y1_q} + (C+1)'(1)))
					span_last = 1'b1;
				else
					row_nx = row_q - C'(1);
			end
			default: begin
			end
		endcase
		if (span_last)
			phase_nx = tsf_pkg::PH_IDLE;
	end

	assign colour = tsf_pkg::colour_of(colour_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= tsf_pkg::PH_IDLE;
			job_q       <= tsf_pkg::JOB_SPLIT;
			colour_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_acc)
				job_q <= tsf_pkg::JOB_SPLIT;
			else if ((state_q == tsf_pkg::SEQ_DIV_WAIT) && div_done
			         && (job_q != tsf_pkg::JOB_SLOPE3))
				job_q <= tsf_pkg::div_job_t'(job_q + 3'd1);

			if ((state_q == tsf_pkg::SEQ_DIV_WAIT) && div_done
			    && (job_q == tsf_pkg::JOB_SLOPE3)) begin
				phase_q <= ((y0_q == y1_q) && (y1_q != y2_q)) ? tsf_pkg::PH_TOP
				                                              : tsf_pkg::PH_BOTTOM;
			end else if (step_acc && span_has) begin
				phase_q <= phase_nx;
			end

			if (step_acc && span_has && span_last)
				colour_q <= (colour_q >= tsf_pkg::COLOUR_LAST) ? 3'd0 : colour_q + 3'd1;

			if (step_acc && span_has)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (load_acc) begin
			x0_q <= sx[0]; y0_q <= sy[0];
			x1_q <= sx[1]; y1_q <= sy[1];
			x2_q <= sx[2]; y2_q <= sy[2];
		end

		if (state_q == tsf_pkg::SEQ_MUL) begin
			prod_q     <= PW'(y1_q - y0_q) * PW'((x2_q >= x0_q) ? (x2_q - x0_q)
			                                                   : (x0_q - x2_q));
			prod_neg_q <= x2_q < x0_q;
		end

		if (div_start) begin
			neg_q      <= div_neg;
			den_zero_q <= div_den == '0;
		end

		if ((state_q == tsf_pkg::SEQ_DIV_WAIT) && div_done) begin
			unique case (job_q)
				tsf_pkg::JOB_SPLIT:  split_q <= fix(x0_q) + div_res;
				tsf_pkg::JOB_SLOPE0: s0_q <= div_res;
				tsf_pkg::JOB_SLOPE1: s1_q <= div_res;
				tsf_pkg::JOB_SLOPE2: s2_q <= div_res;
				tsf_pkg::JOB_SLOPE3: begin
					s3_q <= div_res;
					if ((y0_q == y1_q) && (y1_q != y2_q)) begin
						row_q <= y2_q;
						ex0_q <= fix(x2_q);
						ex1_q <= fix(x2_q);
					end else begin
						row_q <= y0_q;
						ex0_q <= fix(x0_q);
						ex1_q <= fix(x0_q);
					end
				end
				default: begin
				end
			endcase
		end else if (step_acc && span_has) begin
			row_q <= row_nx;
			ex0_q <= ex0_nx;
			ex1_q <= ex1_nx;
		end

		if (step_acc && span_has) begin
			row_s1    <= row_q;
			left_s1   <= (span_a < span_b) ? span_a : span_b;
			right_s1  <= (span_a < span_b) ? span_b : span_a;
			colour_s1 <= colour;
			last_s1   <= span_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign span_row   = row_s1;
	assign span_left  = left_s1;
	assign span_right = right_s1;
	assign red        = colour_s1.red;
	assign green      = colour_s1.green;
	assign blue       = colour_s1.blue;
	assign last_span  = last_s1;

endmodule

`default_nettype wire

// ===== design/tsf_divider.sv =====
// tsf_divider: unsigned restoring divider, one quotient bit per cycle.
// Shared by all slope and split divisions of the span filler; no package use.
`default_nettype none

module tsf_divider #(
	parameter int NUM_BITS = 36,
	parameter int DEN_BITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_BITS-1:0] dividend,
	input  wire logic [DEN_BITS-1:0] divisor,
	output logic                     done,
	output logic      [NUM_BITS-1:0] quotient
);

	localparam int CW = $clog2(NUM_BITS + 1);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [NUM_BITS-1:0] quo_q;

	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   diff;
	logic                fits;

	// dividend bits shift out of the top of quo_q as quotient bits shift in
	assign trial = {rem_q, quo_q[NUM_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== design/tsf_checker.sv =====
// tsf_checker: port-level assertions for triangle_scanline_span_filler.
// Depends on tsf_pkg for the op codes; bound to the top level below.
`default_nettype none

module tsf_checker #(
	parameter int COORD_BITS = 10
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  op,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [COORD_BITS-1:0] span_row,
	input wire logic [COORD_BITS-1:0] span_left,
	input wire logic [COORD_BITS-1:0] span_right,
	input wire logic                  red,
	input wire logic                  green,
	input wire logic                  blue,
	input wire logic                  last_span
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("span word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(span_row) && $stable(span_left)
			&& $stable(span_right) && $stable(red) && $stable(green)
			&& $stable(blue) && $stable(last_span))
		else $error("span word changed while stalled");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> span_left <= span_right)
		else $error("span left beyond right");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == tsf_pkg::OP_LOAD) |=> !in_ready)
		else $error("ready straight after a triangle load");

	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (op == tsf_pkg::OP_STEP)))
		else $error("span word without a step word");

endmodule

bind triangle_scanline_span_filler tsf_checker #(
	.COORD_BITS(COORD_BITS)
) u_tsf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.op         (op),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.span_row   (span_row),
	.span_left  (span_left),
	.span_right (span_right),
	.red        (red),
	.green      (green),
	.blue       (blue),
	.last_span  (last_span)
);

`default_nettype wire

// ===== verif/triangle_scanline_span_filler_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for triangle_scanline_span_filler: loads and span steps in,
// spans checked against a span predictor kept in the bench.
// Depends on tsf_pkg and the span filler RTL.

module triangle_scanline_span_filler_test;

	localparam int COORD_W   = 10;
	localparam int FRAC_W    = 16;
	localparam int FIX_W     = COORD_W + FRAC_W + 2;
	localparam int COORD_MAX = (1 << COORD_W) - 1;
	localparam int WORDS     = 400;
	localparam int CALM_FROM = 340;

	// colour table, entry 0 in the leftmost bit
	localparam bit [0:4] RED_TAB   = 5'b10011;
	localparam bit [0:4] GREEN_TAB = 5'b01001;
	localparam bit [0:4] BLUE_TAB  = 5'b00110;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [FIX_W-1:0] fix_t;

	typedef struct packed {
		coord_t row;
		coord_t left;
		coord_t right;
		logic   red;
		logic   green;
		logic   blue;
		logic   last;
	} span_t;

	class span_scoreboard;
		int                   vx[3];
		int                   vy[3];
		fix_t                 split_x;
		fix_t                 slope[4];
		fix_t                 left_x;
		fix_t                 right_x;
		int                   row;
		tsf_pkg::fill_phase_t phase;
		logic [2:0]           slot;
		span_t                spans_due[$];
		int                   errors;

		function new();
			foreach (vx[i]) begin
				vx[i] = 0;
				vy[i] = 0;
			end
			foreach (slope[i])
				slope[i] = '0;
			split_x = '0;
			left_x  = '0;
			right_x = '0;
			row     = 0;
			phase   = tsf_pkg::PH_IDLE;
			slot    = '0;
			errors  = 0;
		endfunction

		function longint fixed_of(longint v);
			return v * (longint'(1) << FRAC_W);
		endfunction

		// SV signed division already truncates toward zero
		function longint quot(longint n, longint d);
			if (d == 0)
				return 0;
			return n / d;
		endfunction

		function int pixel_at(fix_t v);
			longint w;
			w = longint'(v);
			if (w < 0)
				return 0;
			w = w >>> FRAC_W;
			return (w > COORD_MAX) ? COORD_MAX : int'(w);
		endfunction

		function bit busy();
			return phase != tsf_pkg::PH_IDLE;
		endfunction

		function void load(coord_t ax, coord_t ay, coord_t bx, coord_t by,
				coord_t cx, coord_t cy);
			int     pa[3] = '{0, 0, 1};
			int     pb[3] = '{1, 2, 2};
			int     t;
			longint sx;
			longint prod;
			vx[0] = int'(ax); vy[0] = int'(ay);
			vx[1] = int'(bx); vy[1] = int'(by);
			vx[2] = int'(cx); vy[2] = int'(cy);
			// compare-and-swap network on y
			for (int k = 0; k < 3; k++) begin
				if (vy[pa[k]] > vy[pb[k]]) begin
					t = vx[pa[k]]; vx[pa[k]] = vx[pb[k]]; vx[pb[k]] = t;
					t = vy[pa[k]]; vy[pa[k]] = vy[pb[k]]; vy[pb[k]] = t;
				end
			end
			prod = longint'(vy[1] - vy[0]) * longint'(vx[2] - vx[0]);
			if (vy[2] == vy[0])
				sx = fixed_of(longint'(vx[0]));
			else
				sx = fixed_of(longint'(vx[0]))
					+ quot(fixed_of(prod), longint'(vy[2] - vy[0]));
			split_x  = fix_t'(sx);
			slope[0] = fix_t'(quot(fixed_of(longint'(vx[1] - vx[0])),
				longint'(vy[1] - vy[0])));
			slope[1] = fix_t'(quot(longint'(split_x) - fixed_of(longint'(vx[0])),
				longint'(vy[1] - vy[0])));
			slope[2] = fix_t'(quot(fixed_of(longint'(vx[2] - vx[1])),
				longint'(vy[2] - vy[1])));
			slope[3] = fix_t'(quot(fixed_of(longint'(vx[2])) - longint'(split_x),
				longint'(vy[2] - vy[1])));
			if (vy[0] == vy[1] && vy[1] != vy[2]) begin
				phase   = tsf_pkg::PH_TOP;
				row     = vy[2];
				left_x  = fix_t'(fixed_of(longint'(vx[2])));
				right_x = fix_t'(fixed_of(longint'(vx[2])));
			end else begin
				phase   = tsf_pkg::PH_BOTTOM;
				row     = vy[0];
				left_x  = fix_t'(fixed_of(longint'(vx[0])));
				right_x = fix_t'(fixed_of(longint'(vx[0])));
			end
		endfunction

		// accepted input word: load, or work out the span a step produces
		function void note_word(logic code, coord_t ax, coord_t ay, coord_t bx, coord_t by,
				coord_t cx, coord_t cy);
			span_t s;
			int    a;
			int    b;
			int    r;
			logic  fin;
			if (code == tsf_pkg::OP_LOAD) begin
				load(ax, ay, bx, by, cx, cy);
				return;
			end
			if (phase == tsf_pkg::PH_IDLE)
				return;
			r   = row;
			fin = 1'b0;
			if (phase == tsf_pkg::PH_BOTTOM) begin
				a = pixel_at(left_x);
				b = pixel_at(right_x);
				left_x  = left_x + slope[0];
				right_x = right_x + slope[1];
				if (row >= vy[1]) begin
					if (vy[2] > vy[1]) begin
						phase   = tsf_pkg::PH_TOP;
						row     = vy[2];
						left_x  = fix_t'(fixed_of(longint'(vx[2])));
						right_x = fix_t'(fixed_of(longint'(vx[2])));
					end else begin
						fin = 1'b1;
					end
				end else begin
					row++;
				end
			end else begin
				// top half steps x before the span
				left_x  = left_x - slope[2];
				right_x = right_x - slope[3];
				a = pixel_at(left_x);
				b = pixel_at(right_x);
				if (row <= vy[1] + 1)
					fin = 1'b1;
				else
					row--;
			end
			s.row   = coord_t'(r);
			s.left  = coord_t'((a < b) ? a : b);
			s.right = coord_t'((a < b) ? b : a);
			s.red   = RED_TAB[slot];
			s.green = GREEN_TAB[slot];
			s.blue  = BLUE_TAB[slot];
			s.last  = fin;
			spans_due = {spans_due, s};
			if (fin) begin
				phase = tsf_pkg::PH_IDLE;
				slot  = (slot >= tsf_pkg::COLOUR_LAST) ? 3'd0 : slot + 3'd1;
			end
		endfunction

		function void match(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_span(span_t got);
			span_t want;
			if (spans_due.size() == 0) begin
				$error("span word at row %0d with none expected", got.row);
				errors++;
				return;
			end
			want = spans_due.pop_front();
			match("span_row", 32'(want.row), 32'(got.row));
			match("span_left", 32'(want.left), 32'(got.left));
			match("span_right", 32'(want.right), 32'(got.right));
			match("red", 32'(want.red), 32'(got.red));
			match("green", 32'(want.green), 32'(got.green));
			match("blue", 32'(want.blue), 32'(got.blue));
			match("last_span", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   in_valid   = 1'b0;
	logic   in_ready;
	logic   op         = tsf_pkg::OP_LOAD;
	coord_t vertex_a_x = '0;
	coord_t vertex_a_y = '0;
	coord_t vertex_b_x = '0;
	coord_t vertex_b_y = '0;
	coord_t vertex_c_x = '0;
	coord_t vertex_c_y = '0;
	logic   out_valid;
	logic   out_ready  = 1'b1;
	coord_t span_row;
	coord_t span_left;
	coord_t span_right;
	logic   red;
	logic   green;
	logic   blue;
	logic   last_span;

	span_scoreboard sb = new();
	int words_sent = 0;
	bit steady     = 1'b0;
	int gap_pct    = 0;
	int stall_pct  = 0;
	int stall_left = 0;
	int cyc        = 0;

	triangle_scanline_span_filler #(
		.COORD_BITS(COORD_W),
		.FRAC_BITS (FRAC_W)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.vertex_a_x(vertex_a_x),
		.vertex_a_y(vertex_a_y),
		.vertex_b_x(vertex_b_x),
		.vertex_b_y(vertex_b_y),
		.vertex_c_x(vertex_c_x),
		.vertex_c_y(vertex_c_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.span_row  (span_row),
		.span_left (span_left),
		.span_right(span_right),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.last_span (last_span)
	);

	always #10 clk = ~clk;

	// span monitor and receiver back-pressure
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_span({span_row, span_left, span_right, red, green, blue, last_span});
		cyc <= cyc + 1;
		if (cyc % 128 == 0)
			stall_pct <= 20 * $urandom_range(0, 2);
		if (steady) begin
			out_ready  <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(logic code, coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy);
		in_valid   <= 1'b1;
		op         <= code;
		vertex_a_x <= ax;
		vertex_a_y <= ay;
		vertex_b_x <= bx;
		vertex_b_y <= by;
		vertex_c_x <= cx;
		vertex_c_y <= cy;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_word(code, ax, ay, bx, by, cx, cy);
		words_sent++;
		if (!steady && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// vertex fields are don't-care on a step, so they carry noise
	task automatic send_step();
		send_word(tsf_pkg::OP_STEP, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom));
	endtask

	task automatic run_triangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy, int cap);
		int n;
		n = 0;
		send_word(tsf_pkg::OP_LOAD, ax, ay, bx, by, cx, cy);
		while (sb.busy() && n < cap) begin
			send_step();
			n++;
		end
	endtask

	task automatic random_triangle();
		int     h;
		int     base;
		int     mid;
		int     cap;
		coord_t ax, ay, bx, by, cx, cy;
		// mostly short triangles so most of them run to the last span
		h    = ($urandom_range(0, 99) < 8) ? $urandom_range(0, COORD_MAX)
		                                   : $urandom_range(0, 12);
		base = $urandom_range(0, COORD_MAX - h);
		ay   = coord_t'(base + $urandom_range(0, h));
		by   = coord_t'(base + $urandom_range(0, h));
		cy   = coord_t'(base + $urandom_range(0, h));
		case ($urandom_range(0, 5))
			0: ay = by;
			1: by = cy;
			2: cy = ay;
			default: ;
		endcase
		if ($urandom_range(0, 2) == 0) begin
			mid = $urandom_range(8, COORD_MAX - 8);
			ax  = coord_t'(mid + $urandom_range(0, 16) - 8);
			bx  = coord_t'(mid + $urandom_range(0, 16) - 8);
			cx  = coord_t'(mid + $urandom_range(0, 16) - 8);
		end else begin
			ax = coord_t'($urandom_range(0, COORD_MAX));
			bx = coord_t'($urandom_range(0, COORD_MAX));
			cx = coord_t'($urandom_range(0, COORD_MAX));
		end
		if (h > 12)
			cap = $urandom_range(0, 40);
		else if ($urandom_range(0, 9) == 0)
			cap = $urandom_range(0, h);
		else
			cap = COORD_MAX + 2;
		gap_pct = steady ? 0 : 15 * $urandom_range(0, 2);
		run_triangle(ax, ay, bx, by, cx, cy, cap);
		if ($urandom_range(0, 9) == 0)
			send_step();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_step();                                          // step with nothing loaded
		run_triangle(5, 100, 900, 100, 300, 100, 4);          // all rows equal
		run_triangle(30, 43, 10, 40, 50, 40, 8);              // flat top
		run_triangle(0, 200, 1023, 202, 500, 202, 8);         // flat bottom
		run_triangle(1023, 1023, 0, 1021, 1023, 1022, 8);     // corner of the screen
		run_triangle(0, 0, 1023, 1023, 512, 0, 3);            // full height, cut short by a load
		run_triangle(700, 300, 20, 302, 900, 304, 8);         // general, input already in y order
		send_step();

		while (words_sent < WORDS) begin
			steady = (words_sent >= CALM_FROM);
			random_triangle();
		end
		in_valid <= 1'b0;

		while (sb.spans_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// each load holds the input while its divisions run; this allows for all of them and more
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
